[rtl/nuf_pkg.sv]
// shared types, codes and constants for the nmea/ubx sentence framer
package nuf_pkg;

    localparam int BUFFER_SIZE_DEF = 256;

    localparam logic [7:0] SYNC_NMEA = 8'h24;
    localparam logic [7:0] SYNC_UBX1 = 8'hB5;
    localparam logic [7:0] SYNC_UBX2 = 8'h62;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    localparam logic [39:0] ID_GGA = 40'h474E474741;
    localparam logic [39:0] ID_GSA = 40'h474E475341;
    localparam logic [39:0] ID_RMC = 40'h474E524D43;
    localparam logic [39:0] ID_VTG = 40'h474E565447;

    localparam logic [2:0] ID_LEN_FULL = 3'd5;
    localparam logic [2:0] ID_LEN_OVER = 3'd6;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NMEA = 2'd1;
    localparam logic [1:0] KIND_UBX = 2'd2;

    localparam logic [2:0] SK_NONE = 3'd0;
    localparam logic [2:0] SK_GGA = 3'd1;
    localparam logic [2:0] SK_GSA = 3'd2;
    localparam logic [2:0] SK_RMC = 3'd3;
    localparam logic [2:0] SK_VTG = 3'd4;
    localparam logic [2:0] SK_UNKNOWN = 3'd5;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_NMEA,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_frame;
        logic [1:0] frame_kind;
        logic       frame_end;
        logic       overflow;
        logic [8:0] frame_length;
        logic [2:0] sentence_kind;
    } result_t;

    function automatic logic [2:0] classify(input logic closed, input logic [2:0] len,
                                            input logic [39:0] chars);
        logic [2:0] kind;
        kind = SK_UNKNOWN;
        if (closed && len == ID_LEN_FULL) begin
            if (chars == ID_GGA) kind = SK_GGA;
            else if (chars == ID_GSA) kind = SK_GSA;
            else if (chars == ID_RMC) kind = SK_RMC;
            else if (chars == ID_VTG) kind = SK_VTG;
        end
        return kind;
    endfunction

endpackage

[rtl/nuf_parse.sv]
// byte-wise frame state machine: holds parse state and forms one result per beat
module nuf_parse #(
    parameter int BUFFER_SIZE = nuf_pkg::BUFFER_SIZE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    output nuf_pkg::result_t result
);

    localparam int CW = $clog2(BUFFER_SIZE + 1);
    localparam logic [CW-1:0] LIMIT = CW'(BUFFER_SIZE);

    nuf_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [7:0]      len_lo_reg, len_lo_next;
    logic [16:0]     left_reg, left_next;
    logic [39:0]     id_chars_reg, id_chars_next;
    logic [2:0]      id_len_reg, id_len_next;
    logic            id_closed_reg, id_closed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= nuf_pkg::PH_HUNT;
            count_reg     <= '0;
            len_lo_reg    <= '0;
            left_reg      <= '0;
            id_chars_reg  <= '0;
            id_len_reg    <= '0;
            id_closed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            len_lo_reg    <= len_lo_next;
            left_reg      <= left_next;
            id_chars_reg  <= id_chars_next;
            id_len_reg    <= id_len_next;
            id_closed_reg <= id_closed_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        len_lo_next    = len_lo_reg;
        left_next      = left_reg;
        id_chars_next  = id_chars_reg;
        id_len_next    = id_len_reg;
        id_closed_next = id_closed_reg;

        result               = '0;
        result.data_byte     = rx_byte;
        result.frame_kind    = nuf_pkg::KIND_NONE;
        result.sentence_kind = nuf_pkg::SK_NONE;

        unique case (phase_reg)
            nuf_pkg::PH_HUNT:
            begin
                if (rx_byte == nuf_pkg::SYNC_NMEA)
                begin
                    phase_next        = nuf_pkg::PH_NMEA;
                    count_next        = CW'(1);
                    id_chars_next     = '0;
                    id_len_next       = '0;
                    id_closed_next    = 1'b0;
                    result.in_frame   = 1'b1;
                    result.frame_kind = nuf_pkg::KIND_NMEA;
                end
                else if (rx_byte == nuf_pkg::SYNC_UBX1)
                begin
                    phase_next = nuf_pkg::PH_SYNC2;
                end
            end
            nuf_pkg::PH_SYNC2:
            begin
                if (rx_byte == nuf_pkg::SYNC_UBX2)
                begin
                    phase_next        = nuf_pkg::PH_CLASS;
                    count_next        = CW'(2);
                    result.in_frame   = 1'b1;
                    result.frame_kind = nuf_pkg::KIND_UBX;
                end
                else
                begin
                    phase_next = nuf_pkg::PH_HUNT;
                end
            end
            nuf_pkg::PH_NMEA:
            begin
                result.in_frame   = 1'b1;
                result.frame_kind = nuf_pkg::KIND_NMEA;
                count_next        = count_reg + CW'(1);
                if (!id_closed_reg)
                begin
                    if (rx_byte == nuf_pkg::CHAR_COMMA)
                    begin
                        id_closed_next = 1'b1;
                    end
                    else
                    begin
                        if (id_len_reg < nuf_pkg::ID_LEN_FULL)
                            id_chars_next = {id_chars_reg[31:0], rx_byte};
                        if (id_len_reg < nuf_pkg::ID_LEN_OVER)
                            id_len_next = id_len_reg + 3'd1;
                    end
                end
                if (rx_byte == nuf_pkg::CHAR_LF)
                begin
                    result.frame_end     = 1'b1;
                    result.frame_length  = 9'(count_next);
                    result.sentence_kind = nuf_pkg::classify(id_closed_next, id_len_next,
                                                             id_chars_next);
                    phase_next           = nuf_pkg::PH_HUNT;
                end
                else if (count_next >= LIMIT)
                begin
                    result.overflow = 1'b1;
                    phase_next      = nuf_pkg::PH_HUNT;
                end
            end
            nuf_pkg::PH_CLASS:
            begin
                result.in_frame   = 1'b1;
                result.frame_kind = nuf_pkg::KIND_UBX;
                count_next        = count_reg + CW'(1);
                phase_next        = nuf_pkg::PH_ID;
            end
            nuf_pkg::PH_ID:
            begin
                result.in_frame   = 1'b1;
                result.frame_kind = nuf_pkg::KIND_UBX;
                count_next        = count_reg + CW'(1);
                phase_next        = nuf_pkg::PH_LEN_LO;
            end
            nuf_pkg::PH_LEN_LO:
            begin
                result.in_frame   = 1'b1;
                result.frame_kind = nuf_pkg::KIND_UBX;
                count_next        = count_reg + CW'(1);
                len_lo_next       = rx_byte;
                phase_next        = nuf_pkg::PH_LEN_HI;
            end
            nuf_pkg::PH_LEN_HI:
            begin
                result.in_frame   = 1'b1;
                result.frame_kind = nuf_pkg::KIND_UBX;
                count_next        = count_reg + CW'(1);
                // payload plus two checksum bytes
                left_next         = {1'b0, rx_byte, len_lo_reg} + 17'd2;
                phase_next        = nuf_pkg::PH_BODY;
            end
            nuf_pkg::PH_BODY:
            begin
                result.in_frame   = 1'b1;
                result.frame_kind = nuf_pkg::KIND_UBX;
                count_next        = count_reg + CW'(1);
                if (count_next >= LIMIT)
                begin
                    result.overflow = 1'b1;
                    phase_next      = nuf_pkg::PH_HUNT;
                end
                else
                begin
                    if (left_reg != '0)
                        left_next = left_reg - 17'd1;
                    if (left_next == '0)
                    begin
                        result.frame_end    = 1'b1;
                        result.frame_length = 9'(count_next);
                        phase_next          = nuf_pkg::PH_HUNT;
                    end
                end
            end
        endcase
    end

endmodule

[rtl/nmea_ubx_sentence_framer.sv]
// top level of the nmea/ubx sentence framer with its two-entry output buffer
// One byte is taken per beat and every byte yields one result beat, registered in
// the output register, or in the skid register while the output is stalled. The
// block sustains one byte per clock cycle while in_ready is high. The rate is set
// by the frame state machine, whose next state and result are formed from the
// current state and the byte in the same cycle. Results land in an output register
// backed by a skid register, so a new byte is still accepted in the cycle a waiting
// result is stalled; in_ready drops only while both entries hold results.
module nmea_ubx_sentence_framer #(
    parameter int BUFFER_SIZE = nuf_pkg::BUFFER_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       in_frame,
    output logic [1:0] frame_kind,
    output logic       frame_end,
    output logic       overflow,
    output logic [8:0] frame_length,
    output logic [2:0] sentence_kind
);

    nuf_pkg::result_t result;
    nuf_pkg::result_t out_reg, out_next;
    nuf_pkg::result_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             accept;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    nuf_parse #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .result  (result)
    );

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign data_byte     = out_reg.data_byte;
    assign in_frame      = out_reg.in_frame;
    assign frame_kind    = out_reg.frame_kind;
    assign frame_end     = out_reg.frame_end;
    assign overflow      = out_reg.overflow;
    assign frame_length  = out_reg.frame_length;
    assign sentence_kind = out_reg.sentence_kind;

    // a held skid entry means the output register is full
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_kind_matches_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_frame == (frame_kind != nuf_pkg::KIND_NONE)))
        else $error("frame kind disagrees with in_frame");

    a_end_or_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_end || overflow) |-> in_frame && !(frame_end && overflow))
        else $error("frame end or overflow outside a frame, or both at once");

    a_sentence_only_at_nmea_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sentence_kind != nuf_pkg::SK_NONE)
            |-> frame_end && (frame_kind == nuf_pkg::KIND_NMEA))
        else $error("sentence kind given off an nmea frame end");

endmodule
